[hdl/iisp_pkg.sv]
// shared types, constants and lookup tables for the ini ipv4 settings parser
package iisp_pkg;

  // text bytes parsed per text, the last one stops parsing
  localparam int MAX_BYTES = 8192;
  localparam int CNT_W     = $clog2(MAX_BYTES);
  localparam logic [CNT_W-1:0] BYTE_LIMIT = CNT_W'(MAX_BYTES - 1);

  // register map
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DEFAULT_MASK = '0;
  localparam logic [31:0] DEFAULT_MASK_RST = 32'hFFFF_FF00;

  // wanted section name, compared after lowering the text byte
  localparam int SECT_LEN = 15;
  localparam logic [7:0] SECT_NAME [SECT_LEN] = '{
    8'h72, 8'h61, 8'h70, 8'h69, 8'h2d, 8'h62, 8'h6f, 8'h6f,
    8'h74, 8'h6c, 8'h6f, 8'h61, 8'h64, 8'h65, 8'h72
  };

  // key names: ipaddress, netmask, gateway
  localparam int KEY_IP_LEN   = 9;
  localparam int KEY_MASK_LEN = 7;
  localparam int KEY_GW_LEN   = 7;
  localparam logic [7:0] KEY_IP [KEY_IP_LEN] = '{
    "i", "p", "a", "d", "d", "r", "e", "s", "s"
  };
  localparam logic [7:0] KEY_MASK [KEY_MASK_LEN] = '{
    "n", "e", "t", "m", "a", "s", "k"
  };
  localparam logic [7:0] KEY_GW [KEY_GW_LEN] = '{
    "g", "a", "t", "e", "w", "a", "y"
  };

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_LBR   = "[";
  localparam logic [7:0] CH_RBR   = "]";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_A_UP  = "A";
  localparam logic [7:0] CH_Z_UP  = "Z";

  // beat modes
  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // position within a line
  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_SKIP    = 4'd1,
    PH_S_PRE   = 4'd2,
    PH_S_NAME  = 4'd3,
    PH_S_POST  = 4'd4,
    PH_S_CLOSE = 4'd5,
    PH_K_NAME  = 4'd6,
    PH_K_POST  = 4'd7,
    PH_V_PRE   = 4'd8,
    PH_V_DIG   = 4'd9,
    PH_V_DOT   = 4'd10,
    PH_V_TRAIL = 4'd11
  } line_phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] text_byte;
  } in_beat_t;

  typedef struct packed {
    logic        static_set;
    logic        gateway_set;
    logic [31:0] ip_address;
    logic [31:0] net_mask;
    logic [31:0] gateway_address;
  } out_beat_t;

  // handoff from parser core to output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

endpackage

[hdl/iisp_parse_core.sv]
// input register and per-byte parser state update
module iisp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  iisp_pkg::in_beat_t in_data,
  input  logic [31:0]      default_mask,
  input  logic             res_free,
  output iisp_pkg::result_t res
);
  import iisp_pkg::*;

  // input register
  logic     in_v_r;
  in_beat_t in_r;
  logic     can_go;
  logic     go;

  // parser state
  line_phase_t     phase_r, phase_nxt;
  logic            in_sec_r, in_sec_nxt;
  logic [4:0]      pos_r, pos_nxt;
  logic [2:0]      flags_r, flags_nxt;
  logic [1:0]      oct_idx_r, oct_idx_nxt;
  logic [7:0]      oct_val_r, oct_val_nxt;
  logic [1:0]      dig_cnt_r, dig_cnt_nxt;
  logic [23:0]     partial_r, partial_nxt;
  logic [31:0]     ip_r, ip_nxt;
  logic [31:0]     mask_r, mask_nxt;
  logic [31:0]     gw_r, gw_nxt;
  logic [2:0]      found_r, found_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            stopped_r, stopped_nxt;

  // byte classes
  logic [7:0] c;
  logic [7:0] lc;
  logic       blank;
  logic       digit;
  logic [7:0] dval;

  // stage advances unless an end beat waits on a full output
  assign can_go   = !in_v_r || (in_r.mode == MODE_TEXT) || res_free;
  assign go       = in_v_r && can_go;
  assign in_stall = in_v_r && !can_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  assign c     = in_r.text_byte;
  assign lc    = (c >= CH_A_UP && c <= CH_Z_UP) ? (c | 8'h20) : c;
  assign blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  assign digit = (c >= CH_0) && (c <= CH_9);
  assign dval  = c - CH_0;

  // line end: close a section header or commit a complete value
  logic        val_ok;
  logic [31:0] addr;
  logic        end_sec;
  logic [31:0] end_ip, end_mask, end_gw;
  logic [2:0]  end_found;

  assign val_ok  = ((phase_r == PH_V_DIG) && (oct_idx_r == 2'd3)) || (phase_r == PH_V_TRAIL);
  assign addr    = {partial_r, oct_val_r};
  assign end_sec = (phase_r == PH_S_CLOSE) ? 1'b1 : in_sec_r;

  always_comb begin
    end_ip    = ip_r;
    end_mask  = mask_r;
    end_gw    = gw_r;
    end_found = found_r;
    if (val_ok) begin
      if (flags_r[0]) begin
        end_ip       = addr;
        end_found[0] = 1'b1;
      end else if (flags_r[1]) begin
        end_mask     = addr;
        end_found[1] = 1'b1;
      end else if (flags_r[2]) begin
        end_gw       = addr;
        end_found[2] = 1'b1;
      end
    end
  end

  // one key character against the three candidate names
  logic [2:0]  key_keep;
  line_phase_t key_phase;
  logic [4:0]  key_pos;
  logic        key_term;

  assign key_term = (c == CH_EQ) || blank;

  always_comb begin
    key_keep = '0;
    if (key_term) begin
      key_keep[0] = flags_r[0] && (pos_r == 5'(KEY_IP_LEN));
      key_keep[1] = flags_r[1] && (pos_r == 5'(KEY_MASK_LEN));
      key_keep[2] = flags_r[2] && (pos_r == 5'(KEY_GW_LEN));
    end else begin
      key_keep[0] = flags_r[0] && (pos_r < 5'(KEY_IP_LEN))
                    && (lc == KEY_IP[pos_r[3:0]]);
      key_keep[1] = flags_r[1] && (pos_r < 5'(KEY_MASK_LEN))
                    && (lc == KEY_MASK[pos_r[2:0]]);
      key_keep[2] = flags_r[2] && (pos_r < 5'(KEY_GW_LEN))
                    && (lc == KEY_GW[pos_r[2:0]]);
    end
    key_pos = pos_r;
    if (key_keep == 3'b000) begin
      key_phase = PH_SKIP;
    end else if (key_term) begin
      key_phase = (c == CH_EQ) ? PH_V_PRE : PH_K_POST;
    end else begin
      key_phase = PH_K_NAME;
      key_pos   = pos_r + 5'd1;
    end
  end

  // one section-name character
  line_phase_t sec_phase;
  logic [4:0]  sec_pos;

  always_comb begin
    sec_phase = PH_S_NAME;
    sec_pos   = pos_r;
    if (pos_r >= 5'(SECT_LEN)) begin
      if (blank) begin
        sec_phase = PH_S_POST;
      end else if (c == CH_RBR) begin
        sec_phase = PH_S_CLOSE;
      end else begin
        sec_phase = PH_SKIP;
      end
    end else if (lc == SECT_NAME[pos_r[3:0]]) begin
      sec_pos = pos_r + 5'd1;
    end else begin
      sec_phase = PH_SKIP;
    end
  end

  // next digit of an octet
  logic [11:0] dig_acc;
  assign dig_acc = 12'(oct_val_r) * 12'd10 + 12'(dval);

  // state update for the beat in the input register
  logic do_end;
  logic do_feed;
  logic do_clear_all;

  always_comb begin
    do_end       = 1'b0;
    do_feed      = 1'b0;
    do_clear_all = 1'b0;
    stopped_nxt  = stopped_r;
    cnt_nxt      = cnt_r;
    if (go) begin
      if (in_r.mode == MODE_TEXT) begin
        if (!stopped_r) begin
          if (cnt_r >= BYTE_LIMIT) begin
            do_end      = 1'b1;
            stopped_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            if (c == CH_NUL) begin
              do_end      = 1'b1;
              stopped_nxt = 1'b1;
            end else if (c == CH_LF) begin
              do_end = 1'b1;
            end else begin
              do_feed = 1'b1;
            end
          end
        end
      end else begin
        // an end beat starts a fresh text
        do_clear_all = 1'b1;
        cnt_nxt      = '0;
        stopped_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    in_sec_nxt  = in_sec_r;
    pos_nxt     = pos_r;
    flags_nxt   = flags_r;
    oct_idx_nxt = oct_idx_r;
    oct_val_nxt = oct_val_r;
    dig_cnt_nxt = dig_cnt_r;
    partial_nxt = partial_r;
    ip_nxt      = ip_r;
    mask_nxt    = mask_r;
    gw_nxt      = gw_r;
    found_nxt   = found_r;

    if (do_end || do_clear_all) begin
      in_sec_nxt  = end_sec;
      ip_nxt      = end_ip;
      mask_nxt    = end_mask;
      gw_nxt      = end_gw;
      found_nxt   = end_found;
      phase_nxt   = PH_START;
      pos_nxt     = '0;
      flags_nxt   = 3'b111;
      oct_idx_nxt = '0;
      oct_val_nxt = '0;
      dig_cnt_nxt = '0;
      partial_nxt = '0;
      if (do_clear_all) begin
        in_sec_nxt = 1'b0;
        ip_nxt     = '0;
        mask_nxt   = '0;
        gw_nxt     = '0;
        found_nxt  = '0;
      end
    end else if (do_feed) begin
      unique case (phase_r)
        PH_START: begin
          if (!blank) begin
            if (c == CH_HASH) begin
              phase_nxt = PH_SKIP;
            end else if (c == CH_LBR) begin
              in_sec_nxt = 1'b0;
              phase_nxt  = PH_S_PRE;
            end else if (!in_sec_r) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = key_phase;
              flags_nxt = key_keep;
              pos_nxt   = key_pos;
            end
          end
        end
        PH_S_PRE: begin
          if (!blank) begin
            phase_nxt = sec_phase;
            pos_nxt   = sec_pos;
          end
        end
        PH_S_NAME: begin
          phase_nxt = sec_phase;
          pos_nxt   = sec_pos;
        end
        PH_S_POST: begin
          if (c == CH_RBR) begin
            phase_nxt = PH_S_CLOSE;
          end else if (!blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_S_CLOSE, PH_V_TRAIL: begin
          if (!blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_K_NAME: begin
          phase_nxt = key_phase;
          flags_nxt = key_keep;
          pos_nxt   = key_pos;
        end
        PH_K_POST: begin
          if (c == CH_EQ) begin
            phase_nxt = PH_V_PRE;
          end else if (!blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_V_PRE, PH_V_DOT: begin
          if (digit) begin
            oct_val_nxt = dval;
            dig_cnt_nxt = 2'd1;
            phase_nxt   = PH_V_DIG;
          end else if (!(blank && (phase_r == PH_V_PRE))) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_V_DIG: begin
          if (digit) begin
            if ((dig_cnt_r == 2'd3) || (dig_acc > 12'd255)) begin
              phase_nxt = PH_SKIP;
            end else begin
              oct_val_nxt = dig_acc[7:0];
              dig_cnt_nxt = dig_cnt_r + 2'd1;
            end
          end else if ((c == CH_DOT) && (oct_idx_r != 2'd3)) begin
            partial_nxt = {partial_r[15:0], oct_val_r};
            oct_val_nxt = '0;
            dig_cnt_nxt = '0;
            oct_idx_nxt = oct_idx_r + 2'd1;
            phase_nxt   = PH_V_DOT;
          end else if (blank && (oct_idx_r == 2'd3)) begin
            phase_nxt = PH_V_TRAIL;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      in_sec_r  <= 1'b0;
      pos_r     <= '0;
      flags_r   <= 3'b111;
      oct_idx_r <= '0;
      dig_cnt_r <= '0;
      found_r   <= '0;
      cnt_r     <= '0;
      stopped_r <= 1'b0;
      oct_val_r <= '0;
      partial_r <= '0;
      ip_r      <= '0;
      mask_r    <= '0;
      gw_r      <= '0;
    end else begin
      phase_r   <= phase_nxt;
      in_sec_r  <= in_sec_nxt;
      pos_r     <= pos_nxt;
      flags_r   <= flags_nxt;
      oct_idx_r <= oct_idx_nxt;
      dig_cnt_r <= dig_cnt_nxt;
      found_r   <= found_nxt;
      cnt_r     <= cnt_nxt;
      stopped_r <= stopped_nxt;
      oct_val_r <= oct_val_nxt;
      partial_r <= partial_nxt;
      ip_r      <= ip_nxt;
      mask_r    <= mask_nxt;
      gw_r      <= gw_nxt;
    end
  end

  // result of an end beat, last line folded in unless parsing stopped
  logic [2:0]  fin_found;
  logic [31:0] fin_ip, fin_mask, fin_gw;

  assign fin_found = stopped_r ? found_r : end_found;
  assign fin_ip    = stopped_r ? ip_r : end_ip;
  assign fin_mask  = stopped_r ? mask_r : end_mask;
  assign fin_gw    = stopped_r ? gw_r : end_gw;

  assign res.valid                = do_clear_all;
  assign res.beat.static_set      = fin_found[0];
  assign res.beat.gateway_set     = fin_found[2];
  assign res.beat.ip_address      = fin_ip;
  assign res.beat.net_mask        = fin_found[1] ? fin_mask : default_mask;
  assign res.beat.gateway_address = fin_gw;

`ifndef SYNTHESIS
  // results only come from end beats
  a_res_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (in_v_r && (in_r.mode == MODE_END)))
    else $error("result raised for a text beat");

  // an end beat leaves a fresh text behind
  a_fresh_text: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> ((cnt_r == '0) && !stopped_r && (found_r == 3'b000) && !in_sec_r))
    else $error("state not cleared after end beat");

  // byte counter never passes the limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BYTE_LIMIT)
    else $error("byte counter past limit");

  // no text byte is parsed once stopped
  a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && go && (in_r.mode == MODE_TEXT)) |=> (stopped_r && $stable(cnt_r)))
    else $error("parsing continued after stop");
`endif

endmodule

[hdl/iisp_out_reg.sv]
// result register in front of the output channel
module iisp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  iisp_pkg::result_t  res,
  output logic               res_free,
  output logic               out_valid,
  input  logic               out_stall,
  output iisp_pkg::out_beat_t out_data
);
  import iisp_pkg::*;

  logic      out_v_r;
  out_beat_t out_r;

  // free when empty or being taken this cycle
  assign res_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_free) begin
      out_v_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      out_r <= res.beat;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> res_free)
    else $error("result lost in output register");
`endif

endmodule

[hdl/ini_ipv4_setting_parser.sv]
// top level of the ini ipv4 settings parser
//
//  channel | direction | handshake                  | beat
//  in_     | input     | in_valid / in_stall        | mode, text_byte
//  out_    | output    | out_valid / out_stall      | flags and three addresses
//  cfg_    | input     | apb write, pready always 1 | default_mask at byte 0
//
// one beat per cycle unless in_stall is high: a text beat is parsed in the cycle after it is taken,
// one shallow update of the line state between input and state registers.
// an end beat moves its result from the input register into the output register;
// it waits in the input register while the output register is full.
// rst_n is synchronous; it clears all parser state and sets default_mask.
module ini_ipv4_setting_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  iisp_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output iisp_pkg::out_beat_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [iisp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import iisp_pkg::*;

  logic [31:0] default_mask_r;
  logic        cfg_wr;
  result_t     res;
  logic        res_free;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_mask_r <= DEFAULT_MASK_RST;
    end else if (cfg_wr && (cfg_paddr == ADDR_DEFAULT_MASK)) begin
      default_mask_r <= cfg_pwdata;
    end
  end

  // register read
  always_comb begin
    unique case (cfg_paddr)
      ADDR_DEFAULT_MASK: cfg_prdata = default_mask_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // parser core
  iisp_parse_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .default_mask (default_mask_r),
    .res_free     (res_free),
    .res          (res)
  );

  // output register
  iisp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/tb_top.sv]
// testbench for the ini ipv4 settings parser: directed texts, random texts, idle and stall phases
`timescale 1ns / 1ps

module tb_top;
  import iisp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int BEATS_PER_PHASE  = 475;
  localparam int TEXTS_PER_PHASE  = 10;
  localparam int DRAIN_CYCLES     = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // traffic shaping and bookkeeping
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int          fail_count;
  int          live_beats;
  int          text_count;
  int          report_count;
  int          quiet_cycles;

  // predicted reports waiting for the result channel
  out_beat_t   pending_reports[$];

  // text under construction
  logic [7:0]  text_buf[$];

  // parser shadow state
  bit          ps_in_sec;
  line_phase_t ps_phase;
  int          ps_pos;
  logic [2:0]  ps_keys;
  int          ps_oct_idx;
  int          ps_oct_val;
  int          ps_digits;
  logic [23:0] ps_partial;
  logic [31:0] ps_ip;
  logic [31:0] ps_mask;
  logic [31:0] ps_gw;
  logic [2:0]  ps_found;
  int          ps_count;
  bit          ps_stopped;
  logic [31:0] ps_default_mask;

  ini_ipv4_setting_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known values on every input from time zero
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
  end

  // character classes
  function automatic logic [7:0] to_low(logic [7:0] c);
    return (c >= CH_A_UP && c <= CH_Z_UP) ? c + 8'd32 : c;
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // key name tables: 0 ip, 1 mask, 2 gateway
  function automatic int key_length(int k);
    case (k)
      0: return KEY_IP_LEN;
      1: return KEY_MASK_LEN;
      default: return KEY_GW_LEN;
    endcase
  endfunction

  function automatic logic [7:0] key_letter(int k, int pos);
    case (k)
      0: return KEY_IP[pos];
      1: return KEY_MASK[pos];
      default: return KEY_GW[pos];
    endcase
  endfunction

  // shadow parser: line and text resets
  task automatic restart_line();
    ps_phase   = PH_START;
    ps_pos     = 0;
    ps_keys    = 3'b111;
    ps_oct_idx = 0;
    ps_oct_val = 0;
    ps_digits  = 0;
    ps_partial = '0;
  endtask

  task automatic restart_text();
    restart_line();
    ps_in_sec  = 1'b0;
    ps_ip      = '0;
    ps_mask    = '0;
    ps_gw      = '0;
    ps_found   = '0;
    ps_count   = 0;
    ps_stopped = 1'b0;
  endtask

  // line end: commit a section header or a complete address
  task automatic close_line();
    logic [31:0] addr;
    addr = {ps_partial, ps_oct_val[7:0]};
    if (ps_phase == PH_S_CLOSE) begin
      ps_in_sec = 1'b1;
    end else if ((ps_phase == PH_V_DIG && ps_oct_idx == 3) || ps_phase == PH_V_TRAIL) begin
      if (ps_keys[0]) begin
        ps_ip = addr;
        ps_found[0] = 1'b1;
      end else if (ps_keys[1]) begin
        ps_mask = addr;
        ps_found[1] = 1'b1;
      end else if (ps_keys[2]) begin
        ps_gw = addr;
        ps_found[2] = 1'b1;
      end
    end
    restart_line();
  endtask

  task automatic section_step(logic [7:0] c);
    if (ps_pos >= SECT_LEN) begin
      if (blank_char(c)) ps_phase = PH_S_POST;
      else if (c == CH_RBR) ps_phase = PH_S_CLOSE;
      else ps_phase = PH_SKIP;
    end else if (to_low(c) == SECT_NAME[ps_pos]) begin
      ps_pos++;
    end else begin
      ps_phase = PH_SKIP;
    end
  endtask

  // narrow the candidate keys by one character
  task automatic key_step(logic [7:0] c);
    logic [2:0] keep;
    int         k;
    keep = '0;
    if (c == CH_EQ || blank_char(c)) begin
      for (k = 0; k < 3; k++)
        if (ps_keys[k] && ps_pos == key_length(k)) keep[k] = 1'b1;
      ps_keys = keep;
      if (keep == '0) ps_phase = PH_SKIP;
      else ps_phase = (c == CH_EQ) ? PH_V_PRE : PH_K_POST;
    end else begin
      for (k = 0; k < 3; k++)
        if (ps_keys[k] && ps_pos < key_length(k) && to_low(c) == key_letter(k, ps_pos))
          keep[k] = 1'b1;
      ps_keys = keep;
      if (keep == '0) ps_phase = PH_SKIP;
      else ps_pos++;
    end
  endtask

  task automatic begin_octet(logic [7:0] c);
    ps_oct_val = int'(c) - int'(CH_0);
    ps_digits  = 1;
    ps_phase   = PH_V_DIG;
  endtask

  // one character inside a line
  task automatic feed_char(logic [7:0] c);
    int v;
    case (ps_phase)
      PH_START: begin
        if (!blank_char(c)) begin
          if (c == CH_HASH) begin
            ps_phase = PH_SKIP;
          end else if (c == CH_LBR) begin
            ps_in_sec = 1'b0;
            ps_phase  = PH_S_PRE;
          end else if (!ps_in_sec) begin
            ps_phase = PH_SKIP;
          end else begin
            ps_phase = PH_K_NAME;
            key_step(c);
          end
        end
      end
      PH_S_PRE: begin
        if (!blank_char(c)) begin
          ps_phase = PH_S_NAME;
          section_step(c);
        end
      end
      PH_S_NAME: section_step(c);
      PH_S_POST: begin
        if (c == CH_RBR) ps_phase = PH_S_CLOSE;
        else if (!blank_char(c)) ps_phase = PH_SKIP;
      end
      PH_S_CLOSE, PH_V_TRAIL: begin
        if (!blank_char(c)) ps_phase = PH_SKIP;
      end
      PH_K_NAME: key_step(c);
      PH_K_POST: begin
        if (c == CH_EQ) ps_phase = PH_V_PRE;
        else if (!blank_char(c)) ps_phase = PH_SKIP;
      end
      PH_V_PRE: begin
        if (!blank_char(c)) begin
          if (digit_char(c)) begin_octet(c);
          else ps_phase = PH_SKIP;
        end
      end
      PH_V_DIG: begin
        if (digit_char(c)) begin
          v = ps_oct_val * 10 + (int'(c) - int'(CH_0));
          if (ps_digits >= 3 || v > 255) begin
            ps_phase = PH_SKIP;
          end else begin
            ps_oct_val = v;
            ps_digits++;
          end
        end else if (c == CH_DOT && ps_oct_idx < 3) begin
          ps_partial = {ps_partial[15:0], ps_oct_val[7:0]};
          ps_oct_val = 0;
          ps_digits  = 0;
          ps_oct_idx++;
          ps_phase   = PH_V_DOT;
        end else if (blank_char(c) && ps_oct_idx == 3) begin
          ps_phase = PH_V_TRAIL;
        end else begin
          ps_phase = PH_SKIP;
        end
      end
      PH_V_DOT: begin
        if (digit_char(c)) begin_octet(c);
        else ps_phase = PH_SKIP;
      end
      default: ;
    endcase
  endtask

  // predict one accepted input beat; an end beat yields a report
  task automatic parse_beat(input logic beat_mode, input logic [7:0] c,
                            output bit got, output out_beat_t rep);
    got = 1'b0;
    rep = '0;
    if (beat_mode == MODE_TEXT) begin
      if (!ps_stopped) begin
        live_beats++;
        if (ps_count >= MAX_BYTES - 1) begin
          // byte limit ends the line like a nul
          close_line();
          ps_stopped = 1'b1;
        end else begin
          ps_count++;
          if (c == CH_NUL) begin
            close_line();
            ps_stopped = 1'b1;
          end else if (c == CH_LF) begin
            close_line();
          end else begin
            feed_char(c);
          end
        end
      end
    end else begin
      live_beats++;
      if (!ps_stopped) close_line();
      rep.static_set      = ps_found[0];
      rep.gateway_set     = ps_found[2];
      rep.ip_address      = ps_ip;
      rep.net_mask        = ps_found[1] ? ps_mask : ps_default_mask;
      rep.gateway_address = ps_gw;
      got = 1'b1;
      restart_text();
    end
  endtask

  // text building
  function automatic void put(logic [7:0] c);
    text_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1) == 1) put(c - 8'd32);
    else put(c);
  endfunction

  function automatic void put_blanks(int most);
    int n;
    n = $urandom_range(most);
    repeat (n) begin
      case ($urandom_range(2))
        0: put(CH_SPACE);
        1: put(CH_TAB);
        default: put(CH_CR);
      endcase
    end
  endfunction

  function automatic void put_eol();
    if ($urandom_range(4) == 0) put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic void put_number(int v, int w);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < w) s = {"0", s};
    put_str(s);
  endfunction

  // bracketed header, the wanted name when good, else a near miss
  function automatic void put_section(bit good);
    int i;
    int cut;
    int flaw;
    flaw = good ? -1 : $urandom_range(3);
    cut  = (flaw == 0) ? $urandom_range(SECT_LEN - 1) : SECT_LEN;
    put(CH_LBR);
    put_blanks(2);
    for (i = 0; i < cut; i++) begin
      if (flaw == 1 && i == SECT_LEN / 2) put(CH_HASH);
      else put_case(SECT_NAME[i]);
    end
    if (flaw == 2) put_str("s");
    put_blanks(2);
    if (flaw != 3 || $urandom_range(1) == 0) put(CH_RBR);
    if (flaw == 3) put_str(" x");
    put_blanks(1);
  endfunction

  // dotted quad, with one defect when not good
  function automatic void put_value(bit good);
    int n_oct;
    int flaw;
    int bad_at;
    int i;
    int v;
    flaw   = good ? -1 : $urandom_range(7);
    bad_at = $urandom_range(3);
    n_oct  = (flaw == 2) ? 3 : (flaw == 3) ? 5 : 4;
    for (i = 0; i < n_oct; i++) begin
      if (i > 0) put(CH_DOT);
      if (i == bad_at && flaw == 4) continue;
      if (i == bad_at && flaw == 0) begin
        put_number($urandom_range(999, 256), 3);
      end else if (i == bad_at && flaw == 1) begin
        put_number($urandom_range(255), 4);
      end else if (i == bad_at && flaw == 6) begin
        put_str("1x");
      end else begin
        v = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
        put_number(v, $urandom_range(3, 1));
      end
    end
    if (flaw == 5) put(CH_DOT);
    if (flaw == 7) put_str(" x");
  endfunction

  function automatic void put_key_line(bit good_name, bit good_value);
    int k;
    int i;
    int len;
    int flaw;
    k    = $urandom_range(2);
    len  = key_length(k);
    flaw = good_name ? -1 : $urandom_range(2);
    put_blanks(2);
    for (i = 0; i < len; i++) begin
      if (flaw == 0 && i == len - 1) break;
      if (flaw == 2 && i == 0) put_str("q");
      else put_case(key_letter(k, i));
    end
    if (flaw == 1) put_str("s");
    put_blanks(2);
    if (good_name || $urandom_range(3) != 0) put(CH_EQ);
    put_blanks(2);
    put_value(good_value);
    put_blanks(2);
  endfunction

  // mostly well-formed texts with random content, some noise
  function automatic void build_random_text();
    int n_lines;
    int i;
    int kind;
    logic [7:0] b;
    text_buf.delete();
    if ($urandom_range(9) != 0) begin
      put_section(1'b1);
      put_eol();
    end
    n_lines = $urandom_range(4);
    for (i = 0; i < n_lines; i++) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        put_key_line($urandom_range(5) != 0, $urandom_range(2) != 0);
      end else if (kind < 60) begin
        put_section($urandom_range(1));
      end else if (kind < 70) begin
        put_blanks(1);
        put(CH_HASH);
        repeat ($urandom_range(6)) put(8'($urandom_range(126, 32)));
      end else if (kind < 78) begin
        put_blanks(3);
      end else begin
        repeat ($urandom_range(10, 1)) begin
          b = 8'($urandom_range(255, 1));
          if (b == CH_LF) b = CH_SPACE;
          put(b);
        end
      end
      if (i != n_lines - 1 || $urandom_range(3) != 0) put_eol();
    end
    if (text_buf.size() > 0 && $urandom_range(11) == 0)
      text_buf.insert($urandom_range(text_buf.size() - 1), CH_NUL);
  endfunction

  // send one beat on the input channel
  task automatic send_beat(input logic beat_mode, input logic [7:0] beat_byte);
    bit        got;
    out_beat_t rep;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: beat_mode, text_byte: beat_byte};
    do @(posedge clk); while (in_stall);
    parse_beat(beat_mode, beat_byte, got, rep);
    if (got) pending_reports.push_back(rep);
  endtask

  // the built text followed by its end beat
  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_beat(MODE_TEXT, text_buf[i]);
    send_beat(MODE_END, 8'($urandom));
    text_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write of default_mask, setup then access
  task automatic write_default_mask(logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_DEFAULT_MASK;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ps_default_mask = value;
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < sink_stall_pct);
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_reports
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no prediction waiting");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        report_count++;
        compare_field("static_set", 32'(want.static_set), 32'(out_data.static_set));
        compare_field("gateway_set", 32'(want.gateway_set), 32'(out_data.gateway_set));
        compare_field("ip_address", want.ip_address, out_data.ip_address);
        compare_field("net_mask", want.net_mask, out_data.net_mask);
        compare_field("gateway_address", want.gateway_address, out_data.gateway_address);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // all three keys, extremes, blanks, case, crlf, leading zeros, no final lf
  task automatic test_keys_and_extremes();
    text_buf.delete();
    put_section(1'b1);
    put(CH_LF);
    put_str(" IPAddress = 192.168.1.10");
    put(CH_CR);
    put(CH_LF);
    put_str("netmask=255.255.255.255");
    put(CH_LF);
    put(CH_TAB);
    put_str("GateWay");
    put(CH_TAB);
    put_str("=0.0.0.0  ");
    put(CH_LF);
    send_text();
    text_buf.delete();
    put_section(1'b1);
    put(CH_LF);
    put_str("ipaddress=1.1.1.1");
    put(CH_LF);
    put_str("ipaddress=001.02.3.255");
    send_text();
  endtask

  // bad values and malformed key lines leave earlier values alone
  task automatic test_bad_values();
    text_buf.delete();
    put_section(1'b1);
    put(CH_LF);
    put_str("ipaddress=10.1.1.1");
    put(CH_LF);
    put_str("ipaddress=10.1.1.256");
    put(CH_LF);
    put_str("ipaddress=1.2.3");
    put(CH_LF);
    put_str("ipaddress=1.2.3.4.5");
    put(CH_LF);
    put_str("ipaddress=1..3.4");
    put(CH_LF);
    put_str("gateway 1.2.3.4");
    put(CH_LF);
    put_str("hostname=1.2.3.4");
    put(CH_LF);
    send_text();
  endtask

  // keys outside the section, other sections, comments and blank lines
  task automatic test_outside_section();
    text_buf.delete();
    put_str("ipaddress=1.1.1.1");
    put(CH_LF);
    put_str("# comment");
    put(CH_LF);
    put_str("   ");
    put(CH_LF);
    put_section(1'b1);
    put_str(" x");
    put(CH_LF);
    put_str("netmask=1.1.1.1");
    put(CH_LF);
    put_section(1'b1);
    put(CH_LF);
    put_str("[other]");
    put(CH_LF);
    put_str("gateway=2.2.2.2");
    put(CH_LF);
    send_text();
  endtask

  // nul ends the line and stops parsing until the end beat
  task automatic test_nul_stop();
    text_buf.delete();
    put_section(1'b1);
    put(CH_LF);
    put_str("gateway=9.9.9.9");
    put(CH_NUL);
    put(CH_LF);
    put_str("ipaddress=1.1.1.1");
    put(CH_LF);
    send_text();
  endtask

  // end beat alone reports nothing found and the default mask
  task automatic test_empty_text();
    text_buf.delete();
    send_text();
  endtask

  // the line in progress at the byte limit is committed, later text ignored
  task automatic test_byte_limit();
    int filler;
    text_buf.delete();
    put_section(1'b1);
    put(CH_LF);
    filler = MAX_BYTES - 1 - text_buf.size() - 21;
    repeat (filler) put(CH_LF);
    put_str("ipaddress=10.20.30.40");
    put(CH_LF);
    put_str("gateway=1.2.3.4");
    put(CH_LF);
    send_text();
  endtask

  // random texts under one idle and stall pattern and one default mask
  task automatic test_random_texts(int unsigned idle_pct, int unsigned stall_pct,
                                   logic [31:0] mask);
    int start_beats;
    int texts;
    wait_drained();
    write_default_mask(mask);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start_beats    = live_beats;
    texts          = 0;
    while (live_beats - start_beats < BEATS_PER_PHASE || texts < TEXTS_PER_PHASE) begin
      build_random_text();
      send_text();
      texts++;
    end
  endtask

  // test sequence
  initial begin
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    fail_count      = 0;
    live_beats      = 0;
    text_count      = 0;
    report_count    = 0;
    quiet_cycles    = 0;
    ps_default_mask = DEFAULT_MASK_RST;
    restart_text();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_text();
    test_keys_and_extremes();
    test_bad_values();
    test_outside_section();
    test_nul_stop();
    test_byte_limit();

    test_random_texts(0, 0, 32'h0000_0000);
    test_random_texts(64, 0, 32'hFFFF_FFFF);
    test_random_texts(0, 64, $urandom);
    test_random_texts(17, 17, DEFAULT_MASK_RST);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d texts and %0d parsed beats, %0d reports checked",
             text_count, live_beats, report_count);
    $display("four idle and stall patterns, default mask at both extremes, nul and byte limit");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
